FILE: hdl/binary_fsk_tone_generator_assert.svh
// Assertion macros shared by the checker of the binary FSK tone generator.
`ifndef BINARY_FSK_TONE_GENERATOR_ASSERT_SVH
`define BINARY_FSK_TONE_GENERATOR_ASSERT_SVH

// Overlapping implication, sampled at the rising clock edge outside reset.
`define BFSK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication into the next cycle, sampled at the rising clock edge outside reset.
`define BFSK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bfsk_pkg.sv
// Shared types and constants of the binary FSK tone generator.
package bfsk_pkg;

    localparam int AMP_W    = 15;
    localparam int SPB_W    = 16;
    localparam int STEP_W   = 9;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_STEP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_STEP      = 2'd3;

    localparam logic [AMP_W-1:0]  AMPLITUDE_RST       = 15'd2000;
    localparam logic [SPB_W-1:0]  SAMPLES_PER_BIT_RST = 16'd3520;
    localparam logic [STEP_W-1:0] MARK_STEP_RST       = 9'd4;
    localparam logic [STEP_W-1:0] SPACE_STEP_RST      = 9'd3;

    // Cycles the step reduction needs after a register write.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // Quarter turn in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic valid;
        logic last;
    } bfsk_tag_t;

endpackage

FILE: hdl/bfsk_rom.sv
// Q1.15 sine table memory with a registered read port.
module bfsk_rom
    import bfsk_pkg::*;
#(
    parameter int PHASE_STEPS = 352
)
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [$clog2(PHASE_STEPS)-1:0] addr,
    output logic [SAMPLE_W-1:0]            data
);

    logic [SAMPLE_W-1:0] rom_w [PHASE_STEPS];
    logic [SAMPLE_W-1:0] data_reg;

    // Each entry is round(32768 * sin(2*pi*k/P)) from a truncated Taylor series.
    for (genvar k = 0; k < PHASE_STEPS; k++) begin : g_entry
        localparam longint unsigned U  = 4 * k;
        localparam longint unsigned Q  = U / PHASE_STEPS;
        localparam longint unsigned R0 = U % PHASE_STEPS;
        localparam longint unsigned R  = (Q == 1 || Q == 3) ? PHASE_STEPS - R0 : R0;
        localparam longint unsigned X  = (HALF_PI_Q30 * R) / PHASE_STEPS;
        localparam longint unsigned T1 = ((((X * X) >> 30) * X) >> 30) / 6;
        localparam longint unsigned T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
        localparam longint unsigned T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
        localparam longint unsigned T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
        localparam longint unsigned T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
        localparam longint unsigned T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
        localparam longint unsigned T7 = ((((T6 * X) >> 30) * X) >> 30) / 210;
        localparam longint unsigned T8 = ((((T7 * X) >> 30) * X) >> 30) / 272;
        localparam longint unsigned POS = X + T2 + T4 + T6 + T8;
        localparam longint unsigned NEG = T1 + T3 + T5 + T7;
        localparam longint unsigned S  = (POS > NEG) ? POS - NEG : 0;
        localparam longint unsigned V0 = (S + 16384) >> 15;
        localparam longint unsigned V  = (V0 > 32767) ? 32767 : V0;
        localparam logic [SAMPLE_W-1:0] ENTRY =
            (Q >= 2) ? SAMPLE_W'(65536 - V) : SAMPLE_W'(V);

        assign rom_w[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_w[addr];
        end
    end

    assign data = data_reg;

endmodule

FILE: hdl/bfsk_seq.sv
// Configuration registers, bit timing and tone phase accumulators.
module bfsk_seq
    import bfsk_pkg::*;
#(
    parameter int PHASE_STEPS = 352
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           data_bit,
    input  logic                           en,
    output logic [$clog2(PHASE_STEPS)-1:0] rd_addr,
    output bfsk_tag_t                      tag,
    output logic [AMP_W-1:0]               amplitude
);

    localparam int PW  = $clog2(PHASE_STEPS);
    localparam int RS  = STEP_W + PW + 1;
    localparam int MW  = STEP_W + RS;
    localparam int QPW = STEP_W + PW + 1;
    localparam longint unsigned RECIP = (64'd1 << RS) / PHASE_STEPS;
    localparam logic [STEP_W-1:0] MARK_Q_RST  = STEP_W'(MARK_STEP_RST / PHASE_STEPS);
    localparam logic [STEP_W-1:0] SPACE_Q_RST = STEP_W'(SPACE_STEP_RST / PHASE_STEPS);
    localparam logic [PW-1:0] MARK_RED_RST  = PW'(MARK_STEP_RST % PHASE_STEPS);
    localparam logic [PW-1:0] SPACE_RED_RST = PW'(SPACE_STEP_RST % PHASE_STEPS);
    localparam logic [PW:0]   P_EXT = (PW + 1)'(PHASE_STEPS);

    logic [AMP_W-1:0]  amplitude_reg, amplitude_next;
    logic [SPB_W-1:0]  spb_reg, spb_next;
    logic [STEP_W-1:0] mark_step_reg, mark_step_next;
    logic [STEP_W-1:0] space_step_reg, space_step_next;
    logic [1:0]        settle_reg, settle_next;

    logic [STEP_W-1:0] mark_q_reg, mark_q_next;
    logic [STEP_W-1:0] space_q_reg, space_q_next;
    logic [PW-1:0]     mark_red_reg, mark_red_next;
    logic [PW-1:0]     space_red_reg, space_red_next;

    logic [SPB_W-1:0]  tick_reg, tick_next;
    logic              held_reg, held_next;
    logic [PW-1:0]     mark_phase_reg, mark_phase_next;
    logic [PW-1:0]     space_phase_reg, space_phase_next;
    bfsk_tag_t         tag_reg, tag_next;

    logic              cfg_fire;
    logic              in_fire;
    logic              bit_sel;
    logic              last;
    logic [SPB_W-1:0]  len;
    logic [PW:0]       mark_sum;
    logic [PW:0]       space_sum;
    logic [MW-1:0]     mark_prod;
    logic [MW-1:0]     space_prod;
    logic [QPW-1:0]    mark_rem;
    logic [QPW-1:0]    space_rem;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = en && (settle_reg == 2'd0);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        amplitude_next  = amplitude_reg;
        spb_next        = spb_reg;
        mark_step_next  = mark_step_reg;
        space_step_next = space_step_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_AMPLITUDE:       amplitude_next  = cfg_data[AMP_W-1:0];
                REG_SAMPLES_PER_BIT: spb_next        = cfg_data[SPB_W-1:0];
                REG_MARK_STEP:       mark_step_next  = cfg_data[STEP_W-1:0];
                REG_SPACE_STEP:      space_step_next = cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
        if (cfg_fire)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // The steps are brought below PHASE_STEPS by a reciprocal multiply and one correction.
    always_comb
    begin
        mark_prod    = MW'(mark_step_reg) * MW'(RECIP);
        space_prod   = MW'(space_step_reg) * MW'(RECIP);
        mark_q_next  = mark_prod[RS +: STEP_W];
        space_q_next = space_prod[RS +: STEP_W];
        mark_rem     = QPW'(mark_step_reg) - QPW'(mark_q_reg) * QPW'(PHASE_STEPS);
        space_rem    = QPW'(space_step_reg) - QPW'(space_q_reg) * QPW'(PHASE_STEPS);
        if (mark_rem >= QPW'(PHASE_STEPS))
        begin
            mark_red_next = PW'(mark_rem - QPW'(PHASE_STEPS));
        end
        else
        begin
            mark_red_next = PW'(mark_rem);
        end
        if (space_rem >= QPW'(PHASE_STEPS))
        begin
            space_red_next = PW'(space_rem - QPW'(PHASE_STEPS));
        end
        else
        begin
            space_red_next = PW'(space_rem);
        end
    end

    always_comb
    begin
        len       = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
        bit_sel   = (tick_reg == '0) ? data_bit : held_reg;
        last      = ({1'b0, tick_reg} + 17'd1) >= {1'b0, len};
        rd_addr   = bit_sel ? mark_phase_reg : space_phase_reg;
        mark_sum  = {1'b0, mark_phase_reg} + {1'b0, mark_red_reg};
        space_sum = {1'b0, space_phase_reg} + {1'b0, space_red_reg};

        tick_next        = tick_reg;
        held_next        = held_reg;
        mark_phase_next  = mark_phase_reg;
        space_phase_next = space_phase_reg;
        if (in_fire)
        begin
            held_next = bit_sel;
            tick_next = last ? '0 : tick_reg + SPB_W'(1);
            mark_phase_next  = (mark_sum >= P_EXT) ? PW'(mark_sum - P_EXT) : PW'(mark_sum);
            space_phase_next = (space_sum >= P_EXT) ? PW'(space_sum - P_EXT)
                                                    : PW'(space_sum);
        end

        tag_next = tag_reg;
        if (en)
        begin
            tag_next.valid = in_fire;
            tag_next.last  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg   <= AMPLITUDE_RST;
            spb_reg         <= SAMPLES_PER_BIT_RST;
            mark_step_reg   <= MARK_STEP_RST;
            space_step_reg  <= SPACE_STEP_RST;
            settle_reg      <= 2'd0;
            mark_q_reg      <= MARK_Q_RST;
            space_q_reg     <= SPACE_Q_RST;
            mark_red_reg    <= MARK_RED_RST;
            space_red_reg   <= SPACE_RED_RST;
            tick_reg        <= '0;
            held_reg        <= 1'b0;
            mark_phase_reg  <= '0;
            space_phase_reg <= '0;
            tag_reg         <= '0;
        end
        else
        begin
            amplitude_reg   <= amplitude_next;
            spb_reg         <= spb_next;
            mark_step_reg   <= mark_step_next;
            space_step_reg  <= space_step_next;
            settle_reg      <= settle_next;
            mark_q_reg      <= mark_q_next;
            space_q_reg     <= space_q_next;
            mark_red_reg    <= mark_red_next;
            space_red_reg   <= space_red_next;
            tick_reg        <= tick_next;
            held_reg        <= held_next;
            mark_phase_reg  <= mark_phase_next;
            space_phase_reg <= space_phase_next;
            tag_reg         <= tag_next;
        end
    end

    assign tag       = tag_reg;
    assign amplitude = amplitude_reg;

endmodule

FILE: hdl/bfsk_scale.sv
// Amplitude scaling of the table sine and the output register.
module bfsk_scale
    import bfsk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfsk_tag_t                  tag,
    input  logic [SAMPLE_W-1:0]        rom_data,
    input  logic [AMP_W-1:0]           amplitude,
    output logic                       en,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       bit_end
);

    localparam int PROD_W = 2 * AMP_W;

    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic                       s2_neg_reg;
    logic [PROD_W-1:0]          s2_prod_reg, s2_prod_next;
    logic                       out_valid_reg;
    logic                       bit_end_reg;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [AMP_W-1:0]           mag;
    logic [AMP_W-1:0]           scaled;

    assign en = !out_valid_reg || out_ready;

    always_comb
    begin
        mag          = rom_data[SAMPLE_W-1] ? AMP_W'(-rom_data) : rom_data[AMP_W-1:0];
        s2_prod_next = {{AMP_W{1'b0}}, amplitude} * {{AMP_W{1'b0}}, mag};
        scaled       = s2_prod_reg[PROD_W-1:AMP_W];
        sample_next  = s2_neg_reg ? SAMPLE_W'(-{1'b0, scaled}) : {1'b0, scaled};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= tag.valid;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_last_reg <= tag.last;
            s2_neg_reg  <= rom_data[SAMPLE_W-1];
            s2_prod_reg <= s2_prod_next;
            bit_end_reg <= s2_last_reg;
            sample_reg  <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign bit_end   = bit_end_reg;

endmodule

FILE: hdl/binary_fsk_tone_generator.sv
// Each data bit's sample passes the table read, product and output registers in turn.
// Throughput: one tick per cycle while the output is free, set by the table's single read port.
// A register write holds off input transfers while the steps are reduced.
// Reset: asynchronous active low; registers return to their defaults, phases and count to zero.
// Top level of the binary FSK tone generator.
module binary_fsk_tone_generator
    import bfsk_pkg::*;
#(
    parameter int PHASE_STEPS = 352
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       data_bit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       bit_end
);

    localparam int PW = $clog2(PHASE_STEPS);

    logic                en;
    logic [PW-1:0]       rd_addr;
    bfsk_tag_t           tag;
    logic [AMP_W-1:0]    amplitude;
    logic [SAMPLE_W-1:0] rom_data;

    bfsk_seq #(
        .PHASE_STEPS(PHASE_STEPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_bit  (data_bit),
        .en        (en),
        .rd_addr   (rd_addr),
        .tag       (tag),
        .amplitude (amplitude)
    );

    bfsk_rom #(
        .PHASE_STEPS(PHASE_STEPS)
    ) u_rom (
        .clk  (clk),
        .en   (en),
        .addr (rd_addr),
        .data (rom_data)
    );

    bfsk_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .rom_data  (rom_data),
        .amplitude (amplitude),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .bit_end   (bit_end)
    );

endmodule

FILE: hdl/bfsk_checker.sv
// Port-level checks of the binary FSK tone generator and their binding.
`include "binary_fsk_tone_generator_assert.svh"

module bfsk_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] sample,
    input logic               bit_end
);

    // A stalled result keeps its value until the transfer.
    `BFSK_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(bit_end), "output changed while stalled")

    // A register write blocks the data input while the steps settle.
    `BFSK_ASSERT_NXT(a_cfg_settle, cfg_valid && cfg_ready, !in_ready, "input taken right after a register write")

    // The scaled sine never reaches the most negative code.
    `BFSK_ASSERT_IMP(a_sample_range, out_valid, sample != 16'sh8000, "sample out of range")

endmodule

bind binary_fsk_tone_generator bfsk_checker u_bfsk_checker (.*);
